// ===== rtl/ffbf_pkg.sv =====
// ----------------------------------------------------------------------------
// FLAC frame boundary finder package
// Shared types, constants and header decode tables of the frame finder.
// ----------------------------------------------------------------------------
package ffbf_pkg;

    localparam int FRAME_OFFSET_W = 32;
    localparam int FRAME_LEN_W    = 24;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;

    localparam logic [FRAME_LEN_W-1:0] LEN_MAX = 24'hFF_FFFF;

    localparam logic [15:0] SYNC_MASK = 16'hFFFE;
    localparam logic [15:0] SYNC_WORD = 16'hFFF8;

    localparam logic EV_FRAME    = 1'b0;
    localparam logic EV_CHAN_ERR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 2'd3;

    localparam logic [15:0] RST_BLOCK_SIZE  = 16'd4096;
    localparam logic [17:0] RST_SAMPLE_RATE = 18'd44100;
    localparam logic [23:0] RST_MIN_FRAME   = 24'd0;
    localparam logic [3:0]  RST_CHANNELS    = 4'd2;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_RATE,
        PH_CHAN,
        PH_NUM1,
        PH_NUMN,
        PH_CRC,
        PH_SEEK,
        PH_VERIFY
    } phase_t;

    typedef struct packed {
        logic       hdr_ok;
        logic       chan_ok;
        logic [2:0] num_extra;
    } hdr_flags_t;

    typedef struct packed {
        logic                      emit;
        logic                      event_kind;
        logic [FRAME_OFFSET_W-1:0] frame_offset;
        logic [FRAME_LEN_W-1:0]    frame_length;
    } result_t;

    function automatic logic [15:0] block_size_decode(input logic [3:0] code);
        logic [15:0] bs;
        unique case (code)
            4'd1:    bs = 16'd192;
            4'd2:    bs = 16'd576;
            4'd3:    bs = 16'd1152;
            4'd4:    bs = 16'd2304;
            4'd5:    bs = 16'd4608;
            4'd8:    bs = 16'd256;
            4'd9:    bs = 16'd512;
            4'd10:   bs = 16'd1024;
            4'd11:   bs = 16'd2048;
            4'd12:   bs = 16'd4096;
            4'd13:   bs = 16'd8192;
            4'd14:   bs = 16'd16384;
            4'd15:   bs = 16'd32768;
            default: bs = 16'd0;
        endcase
        return bs;
    endfunction

    function automatic logic [17:0] sample_rate_decode(input logic [3:0] code);
        logic [17:0] sr;
        unique case (code)
            4'd1:    sr = 18'd88200;
            4'd2:    sr = 18'd176400;
            4'd3:    sr = 18'd192000;
            4'd4:    sr = 18'd8000;
            4'd5:    sr = 18'd16000;
            4'd6:    sr = 18'd22050;
            4'd7:    sr = 18'd24000;
            4'd8:    sr = 18'd32000;
            4'd9:    sr = 18'd44100;
            4'd10:   sr = 18'd48000;
            4'd11:   sr = 18'd96000;
            default: sr = 18'd0;
        endcase
        return sr;
    endfunction

    // Number of bytes that follow the first byte of the coded frame number.
    function automatic logic [2:0] coded_extra(input logic [7:0] b);
        logic [2:0] n;
        unique casez (b)
            8'b110?????: n = 3'd1;
            8'b1110????: n = 3'd2;
            8'b11110???: n = 3'd3;
            8'b111110??: n = 3'd4;
            8'b1111110?: n = 3'd5;
            8'b11111110: n = 3'd6;
            8'b11111111: n = 3'd7;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/ffbf_byte_if.sv =====
// ----------------------------------------------------------------------------
// FLAC frame finder byte channel
// Valid/ready channel that carries one stream byte and its end marker.
// ----------------------------------------------------------------------------
interface ffbf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/ffbf_event_if.sv =====
// ----------------------------------------------------------------------------
// FLAC frame finder event channel
// Valid/ready channel that carries one frame or error event.
// ----------------------------------------------------------------------------
interface ffbf_event_if;
    import ffbf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      event_kind;
    logic [FRAME_OFFSET_W-1:0] frame_offset;
    logic [FRAME_LEN_W-1:0]    frame_length;

    modport source (output valid, output event_kind, output frame_offset,
                    output frame_length, input ready);
    modport sink (input valid, input event_kind, input frame_offset,
                  input frame_length, output ready);
endinterface

// ===== rtl/flac_frame_boundary_finder.sv =====
// ----------------------------------------------------------------------------
// FLAC frame boundary finder
// Scans a FLAC byte stream and reports frame start offsets, lengths and channel errors.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and keeps that rate indefinitely
// as long as events are taken. Each accepted byte is held in an input
// register, decided combinationally by the header checker and parser core,
// and any resulting event is placed in an output register, from which it is
// shown; a held event that is not taken delays this step. While a held
// event is not taken, the byte in the input register waits and the byte
// side stalls, whether or not that byte would produce an event. There is no
// memory and no start-up sweep.
// Configuration must be written while no word is in flight.
module flac_frame_boundary_finder #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ffbf_byte_if.sink                          byte_stream,
    ffbf_event_if.source                       frame_events,
    input  logic                               cfg_we,
    input  logic [ffbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffbf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ffbf_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;

    logic [15:0] block_size_reg;
    logic [17:0] sample_rate_reg;
    logic [23:0] min_frame_reg;
    logic [3:0]  channels_reg;

    logic        accept;
    logic        fire;
    hdr_flags_t  flags;
    result_t     result;

    assign fire              = in_valid_reg && (!out_valid_reg || frame_events.ready);
    assign byte_stream.ready = !in_valid_reg || fire;
    assign accept            = byte_stream.valid && byte_stream.ready;

    assign in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? result.emit
                                 : (frame_events.ready ? 1'b0 : out_valid_reg);

    ffbf_hdr_check u_hdr_check (
        .data_byte            (in_byte_reg),
        .expected_block_size  (block_size_reg),
        .expected_sample_rate (sample_rate_reg),
        .channel_count        (channels_reg),
        .flags                (flags)
    );

    ffbf_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .min_gap   (min_frame_reg),
        .flags     (flags),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_last_reg <= byte_stream.last_byte;
        end
        if (fire && result.emit)
        begin
            out_res_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg  <= RST_BLOCK_SIZE;
            sample_rate_reg <= RST_SAMPLE_RATE;
            min_frame_reg   <= RST_MIN_FRAME;
            channels_reg    <= RST_CHANNELS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_SIZE:  block_size_reg  <= cfg_data[15:0];
                CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data[17:0];
                CFG_MIN_FRAME:   min_frame_reg   <= cfg_data[23:0];
                CFG_CHANNELS:    channels_reg    <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    assign frame_events.valid        = out_valid_reg;
    assign frame_events.event_kind   = out_res_reg.event_kind;
    assign frame_events.frame_offset = out_res_reg.frame_offset;
    assign frame_events.frame_length = out_res_reg.frame_length;
endmodule

// ===== rtl/ffbf_hdr_check.sv =====
// ----------------------------------------------------------------------------
// FLAC frame header byte checker
// Decodes one byte as rate byte, channel byte and coded number head.
// ----------------------------------------------------------------------------
module ffbf_hdr_check (
    input  logic [7:0]           data_byte,
    input  logic [15:0]          expected_block_size,
    input  logic [17:0]          expected_sample_rate,
    input  logic [3:0]           channel_count,
    output ffbf_pkg::hdr_flags_t flags
);
    import ffbf_pkg::*;

    logic [15:0] bs;
    logic [17:0] sr;
    logic [3:0]  ch;

    assign bs = block_size_decode(data_byte[7:4]);
    assign sr = sample_rate_decode(data_byte[3:0]);

    // Channel codes above seven count as a stereo layout.
    assign ch = data_byte[7] ? 4'd2 : ({1'b0, data_byte[6:4]} + 4'd1);

    assign flags.hdr_ok    = (bs != 16'd0) && (sr != 18'd0)
                           && (bs == expected_block_size)
                           && (sr == expected_sample_rate);
    assign flags.chan_ok   = (ch == channel_count);
    assign flags.num_extra = coded_extra(data_byte);
endmodule

// ===== rtl/ffbf_core.sv =====
// ----------------------------------------------------------------------------
// FLAC frame finder parser core
// Holds the stream state and decides each byte combinationally.
// ----------------------------------------------------------------------------
module ffbf_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [23:0]          min_gap,
    input  ffbf_pkg::hdr_flags_t flags,
    output ffbf_pkg::result_t    result
);
    import ffbf_pkg::*;

    localparam int CMP_W = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             prev_byte_reg, prev_byte_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] cand_reg, cand_next;
    logic [2:0]             remain_reg, remain_next;

    logic                   is_sync;
    logic [OFFSET_BITS-1:0] pair_pos;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] dist_pair;
    logic [OFFSET_BITS-1:0] dist_end;
    logic [OFFSET_BITS-1:0] dist_cand;
    logic [OFFSET_BITS-1:0] len_sel;
    logic [63:0]            len_wide;
    logic [63:0]            start_wide;
    logic [2:0]             remain_dec;
    logic                   far_enough;
    logic                   res_emit;
    logic                   res_kind;

    assign is_sync    = (({prev_byte_reg, data_byte} & SYNC_MASK) == SYNC_WORD);
    assign pair_pos   = pos_reg - OFFSET_BITS'(1);
    assign pos_inc    = pos_reg + OFFSET_BITS'(1);
    assign dist_pair  = pair_pos - start_reg;
    assign dist_end   = pos_inc - start_reg;
    assign dist_cand  = cand_reg - start_reg;
    assign far_enough = CMP_W'(dist_pair) >= CMP_W'(min_gap);
    assign remain_dec = remain_reg - 3'd1;
    assign start_wide = 64'(start_reg);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (is_sync)
                begin
                    phase_next = PH_RATE;
                end
            end
            PH_RATE:   phase_next = flags.hdr_ok ? PH_CHAN : PH_HUNT;
            PH_CHAN:   phase_next = flags.chan_ok ? PH_NUM1 : PH_HUNT;
            PH_NUM1:   phase_next = (flags.num_extra != 3'd0) ? PH_NUMN : PH_CRC;
            PH_NUMN:
            begin
                if (remain_dec == 3'd0)
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:    phase_next = PH_SEEK;
            PH_SEEK:
            begin
                if (is_sync && !last_byte && far_enough)
                begin
                    phase_next = PH_VERIFY;
                end
            end
            PH_VERIFY: phase_next = flags.hdr_ok ? PH_CHAN : PH_SEEK;
            default:   phase_next = PH_HUNT;
        endcase
        if (last_byte)
        begin
            phase_next = PH_HUNT;
        end
    end

    always_comb
    begin
        prev_byte_next = data_byte;
        pos_next       = pos_inc;
        start_next     = start_reg;
        cand_next      = cand_reg;
        remain_next    = remain_reg;
        res_emit       = 1'b0;
        res_kind       = EV_FRAME;
        len_sel        = dist_end;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (is_sync)
                begin
                    cand_next = pair_pos;
                end
            end
            PH_RATE:
            begin
                if (flags.hdr_ok)
                begin
                    start_next = cand_reg;
                end
            end
            PH_CHAN:
            begin
                if (!flags.chan_ok)
                begin
                    res_emit = 1'b1;
                    res_kind = EV_CHAN_ERR;
                end
            end
            PH_NUM1:   remain_next = flags.num_extra;
            PH_NUMN:   remain_next = remain_dec;
            PH_CRC:    prev_byte_next = 8'd0;
            PH_SEEK:
            begin
                if (is_sync)
                begin
                    if (last_byte)
                    begin
                        res_emit = 1'b1;
                        len_sel  = dist_pair;
                    end
                    else if (far_enough)
                    begin
                        cand_next = pair_pos;
                    end
                end
                else if (last_byte)
                begin
                    res_emit = 1'b1;
                end
            end
            PH_VERIFY:
            begin
                if (flags.hdr_ok)
                begin
                    res_emit   = 1'b1;
                    len_sel    = dist_cand;
                    start_next = cand_reg;
                end
                else if (last_byte)
                begin
                    res_emit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (last_byte)
        begin
            prev_byte_next = 8'd0;
            pos_next       = '0;
            start_next     = '0;
            cand_next      = '0;
            remain_next    = 3'd0;
        end
    end

    assign len_wide            = 64'(len_sel);
    assign result.emit         = res_emit;
    assign result.event_kind   = res_kind;
    assign result.frame_offset = start_wide[FRAME_OFFSET_W-1:0];
    assign result.frame_length = (res_kind == EV_CHAN_ERR) ? '0 :
                                 ((|len_wide[63:FRAME_LEN_W]) ? LEN_MAX
                                                              : len_wide[FRAME_LEN_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            prev_byte_reg <= 8'd0;
            pos_reg       <= '0;
            start_reg     <= '0;
            cand_reg      <= '0;
            remain_reg    <= 3'd0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            prev_byte_reg <= prev_byte_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            cand_reg      <= cand_next;
            remain_reg    <= remain_next;
        end
    end
endmodule

// ===== rtl/ffbf_checker.sv =====
// ----------------------------------------------------------------------------
// FLAC frame finder port checker
// Port-level assertions on the frame finder, attached by a bind statement.
// ----------------------------------------------------------------------------
module ffbf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                event_kind,
    input logic [ffbf_pkg::FRAME_OFFSET_W-1:0] frame_offset,
    input logic [ffbf_pkg::FRAME_LEN_W-1:0]    frame_length
);
    import ffbf_pkg::*;

    // An error word never carries a frame length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_CHAN_ERR) |-> frame_length == '0)
        else $error("error word with nonzero frame length");

    // The byte side stalls only while a held word is not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("byte side stalled without output backpressure");

    // Leaving reset, no word is shown.
    assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("word shown right after reset");

    // A word that is not taken holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(frame_offset) && $stable(frame_length))
        else $error("stalled word changed");
endmodule

bind flac_frame_boundary_finder ffbf_checker u_ffbf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (byte_stream.ready),
    .out_valid    (frame_events.valid),
    .out_ready    (frame_events.ready),
    .event_kind   (frame_events.event_kind),
    .frame_offset (frame_events.frame_offset),
    .frame_length (frame_events.frame_length)
);
